FILE: rtl/core/tmq_pkg.sv
package tmq_pkg;

	// Operation codes carried on s_tuser.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// Result kinds carried on m_tuser.
	localparam logic [2:0] KIND_ADDED     = 3'd0;
	localparam logic [2:0] KIND_FULL      = 3'd1;
	localparam logic [2:0] KIND_CANCELLED = 3'd2;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
	localparam logic [2:0] KIND_EXPIRED   = 3'd4;
	localparam logic [2:0] KIND_TICK_DONE = 3'd5;

	localparam int unsigned SLOT_BITS = 4;
	localparam int unsigned GEN_BITS  = 8;
	localparam int unsigned PER_BITS  = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADD_WR,
		ST_CANCEL,
		ST_REARM,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_FINAL
	} state_t;

	// Control for the minimum-search unit, one table entry per sample.
	typedef struct packed {
		logic clear;
		logic sample;
		logic cand_valid;
		logic cand_due;
	} scan_ctl_t;

endpackage

FILE: rtl/core/tmq_ram.sv
module tmq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/tmq_scan.sv
// Running minimum over one pass of the table: the earliest pending expiry and
// the earliest due entry, ties going to the entry seen first (the lower slot).
module tmq_scan #(
	parameter int IDXW      = 4,
	parameter int TIME_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmq_pkg::scan_ctl_t    ctl,
	input  logic [IDXW-1:0]       idx,
	input  logic [TIME_BITS-1:0]  value,
	output logic                  best_any,
	output logic [TIME_BITS-1:0]  best,
	output logic                  pick_any,
	output logic [IDXW-1:0]       pick
);

	logic [TIME_BITS-1:0] pick_exp_q;
	logic                 best_any_q;
	logic                 pick_any_q;
	logic [TIME_BITS-1:0] best_q;
	logic [IDXW-1:0]      pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_any_q <= 1'b0;
			pick_any_q <= 1'b0;
		end else if (ctl.clear) begin
			best_any_q <= 1'b0;
			pick_any_q <= 1'b0;
		end else if (ctl.sample) begin
			if (ctl.cand_valid && (!best_any_q || value < best_q)) begin
				best_any_q <= 1'b1;
			end
			if (ctl.cand_due && (!pick_any_q || value < pick_exp_q)) begin
				pick_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && ctl.sample) begin
			if (ctl.cand_valid && (!best_any_q || value < best_q)) begin
				best_q <= value;
			end
			if (ctl.cand_due && (!pick_any_q || value < pick_exp_q)) begin
				pick_exp_q <= value;
				pick_q     <= idx;
			end
		end
	end

	assign best_any = best_any_q;
	assign best     = best_q;
	assign pick_any = pick_any_q;
	assign pick     = pick_q;

endmodule

FILE: rtl/core/timer_expiry_queue_core.sv
// Timer table with add, cancel and tick. Each accepted word is handled on its
// own: the block reads the expiry memory one slot a cycle to make a pass over
// the table. An add or a cancel costs one pass and returns one word. A tick
// costs one pass for each timer that expires plus one closing pass, and each
// expired timer adds a rearm step and a read and load step for its output, so
// a tick that expires k timers returns k + 1 words, the last one marked by
// tlast. Every result word carries the earliest pending expiry as it stands
// after the whole operation, which is why a tick records its expired slots in
// a small list and plays them out only after its final pass. The output
// register lets the next word be accepted while the last result still waits
// on m_tready.
module timer_expiry_queue_core #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 48,
	localparam int IN_BITS   = 2 * TIME_BITS + 32 + 4 + 8,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = TIME_BITS + 14,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// Fields from bit 0 up: expire_time, period, slot, generation, now_time.
	input  logic [IN_W-1:0]  s_tdata,
	// Fields from bit 0 up: op.
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// Fields from bit 0 up: timer_slot, timer_generation, earliest_changed,
	// next_valid, next_expiry.
	output logic [OUT_W-1:0] m_tdata,
	// Fields from bit 0 up: kind.
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);

	localparam int IDXW = $clog2(NUM_TIMERS);
	localparam int SB   = tmq_pkg::SLOT_BITS;
	localparam int GB   = tmq_pkg::GEN_BITS;
	localparam int PB   = tmq_pkg::PER_BITS;

	// Captured input word.
	logic [1:0]           op_q;
	logic [TIME_BITS-1:0] exp_in_q;
	logic [PB-1:0]        per_in_q;
	logic [SB-1:0]        slot_in_q;
	logic [GB-1:0]        gen_in_q;
	logic [TIME_BITS-1:0] now_q;

	// Per-slot state kept in flops: valid bits, tags and the due set of a tick.
	logic [NUM_TIMERS-1:0] valid_q;
	logic [GB-1:0]         gen_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] due_q;

	tmq_pkg::state_t state_q, state_d;

	// Scan sequencing.
	logic [IDXW:0]   cnt_q;
	logic            rd_vld_s1;
	logic [IDXW-1:0] idx_s1;
	logic            first_q;
	logic            issue;
	logic            scan_done;
	logic            scan_start;

	// Expired-slot list of a tick.
	logic [IDXW:0]   fill_q;
	logic [IDXW:0]   emit_q;

	// Pending single result and the post-operation earliest expiry.
	logic [2:0]           res_kind_q;
	logic [SB-1:0]        res_slot_q;
	logic [GB-1:0]        res_gen_q;
	logic                 res_ec_q;
	logic                 nv_q;
	logic [TIME_BITS-1:0] ne_q;

	// Output register.
	logic                 m_tvalid_q;
	logic [2:0]           o_kind_q;
	logic [SB-1:0]        o_slot_q;
	logic [GB-1:0]        o_gen_q;
	logic                 o_ec_q;
	logic                 o_nv_q;
	logic [TIME_BITS-1:0] o_ne_q;
	logic                 o_last_q;
	logic                 out_free;

	// Memories.
	logic                 exp_we;
	logic [IDXW-1:0]      exp_waddr;
	logic [TIME_BITS-1:0] exp_wdata;
	logic [TIME_BITS-1:0] exp_rdata;
	logic                 per_we;
	logic [PB-1:0]        per_rdata;
	logic                 list_we;
	logic [IDXW-1:0]      list_rdata;

	// Scan unit.
	tmq_pkg::scan_ctl_t   scan_ctl;
	logic                 best_any;
	logic [TIME_BITS-1:0] best;
	logic                 pick_any;
	logic [IDXW-1:0]      pick;

	// Misc combinational.
	logic                 accept;
	logic                 free_any;
	logic [IDXW-1:0]      free_idx;
	logic                 due_now;
	logic                 cancel_hit;
	logic [IDXW-1:0]      cancel_idx;
	logic [TIME_BITS:0]   rearm_sum;
	logic [TIME_BITS-1:0] rearm_exp;
	logic                 add_ec;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == tmq_pkg::ST_IDLE);
	assign out_free   = !m_tvalid_q || m_tready;
	assign issue      = (cnt_q < (IDXW+1)'(NUM_TIMERS));
	assign scan_done  = (state_q == tmq_pkg::ST_SCAN) && !issue && !rd_vld_s1;
	assign scan_start = (state_d == tmq_pkg::ST_SCAN) && (state_q != tmq_pkg::ST_SCAN);

	// Lowest free slot.
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDXW'(i);
			end
		end
	end

	assign add_ec     = !best_any || (exp_in_q < best);
	assign cancel_idx = IDXW'(slot_in_q);
	assign cancel_hit = (32'(slot_in_q) < 32'(NUM_TIMERS)) && valid_q[cancel_idx] &&
	                    (gen_q[cancel_idx] == gen_in_q);
	assign due_now    = valid_q[idx_s1] && (exp_rdata <= now_q);

	// A rearm saturates at the largest time value.
	assign rearm_sum  = {1'b0, now_q} + (TIME_BITS+1)'(per_rdata);
	assign rearm_exp  = rearm_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : rearm_sum[TIME_BITS-1:0];

	// Scan unit control: only tick passes look for due entries.
	always_comb begin
		scan_ctl.clear      = scan_start;
		scan_ctl.sample     = rd_vld_s1;
		scan_ctl.cand_valid = valid_q[idx_s1];
		scan_ctl.cand_due   = (op_q == tmq_pkg::OP_TICK) &&
		                      (first_q ? due_now : due_q[idx_s1]);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmq_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						tmq_pkg::OP_ADD, tmq_pkg::OP_TICK: state_d = tmq_pkg::ST_SCAN;
						tmq_pkg::OP_CANCEL:                state_d = tmq_pkg::ST_CANCEL;
						default:                           state_d = tmq_pkg::ST_IDLE;
					endcase
				end
			end
			tmq_pkg::ST_SCAN: begin
				if (scan_done) begin
					if (op_q == tmq_pkg::OP_ADD) begin
						state_d = tmq_pkg::ST_ADD_WR;
					end else if (op_q == tmq_pkg::OP_CANCEL) begin
						state_d = tmq_pkg::ST_FINAL;
					end else if (pick_any) begin
						state_d = tmq_pkg::ST_REARM;
					end else begin
						state_d = tmq_pkg::ST_EMIT_RD;
					end
				end
			end
			tmq_pkg::ST_ADD_WR:  state_d = tmq_pkg::ST_FINAL;
			tmq_pkg::ST_CANCEL:  state_d = tmq_pkg::ST_SCAN;
			tmq_pkg::ST_REARM:   state_d = tmq_pkg::ST_SCAN;
			tmq_pkg::ST_EMIT_RD: begin
				state_d = (emit_q == fill_q) ? tmq_pkg::ST_FINAL : tmq_pkg::ST_EMIT_LD;
			end
			tmq_pkg::ST_EMIT_LD: begin
				if (out_free) begin
					state_d = tmq_pkg::ST_EMIT_RD;
				end
			end
			tmq_pkg::ST_FINAL: begin
				if (out_free) begin
					state_d = tmq_pkg::ST_IDLE;
				end
			end
			default: state_d = tmq_pkg::ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		exp_we    = 1'b0;
		exp_waddr = pick;
		exp_wdata = rearm_exp;
		per_we    = 1'b0;
		list_we   = 1'b0;
		unique case (state_q)
			tmq_pkg::ST_ADD_WR: begin
				exp_we    = free_any;
				exp_waddr = free_idx;
				exp_wdata = exp_in_q;
				per_we    = free_any;
			end
			tmq_pkg::ST_REARM: begin
				exp_we = (per_rdata != '0);
			end
			tmq_pkg::ST_SCAN: begin
				list_we = scan_done && (op_q == tmq_pkg::OP_TICK) && pick_any;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tmq_pkg::ST_IDLE;
			valid_q    <= '0;
			due_q      <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			first_q    <= 1'b0;
			fill_q     <= '0;
			emit_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				gen_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (scan_start) begin
				cnt_q <= '0;
			end else if (state_q == tmq_pkg::ST_SCAN && issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= (state_q == tmq_pkg::ST_SCAN) && issue;

			if (accept) begin
				first_q <= 1'b1;
				fill_q  <= '0;
				emit_q  <= '0;
			end

			if (rd_vld_s1 && first_q && op_q == tmq_pkg::OP_TICK) begin
				due_q[idx_s1] <= due_now;
			end

			if (list_we) begin
				due_q[pick] <= 1'b0;
				fill_q      <= fill_q + 1'b1;
				first_q     <= 1'b0;
			end

			if (state_q == tmq_pkg::ST_ADD_WR && free_any) begin
				valid_q[free_idx] <= 1'b1;
				gen_q[free_idx]   <= gen_q[free_idx] + 1'b1;
			end
			if (state_q == tmq_pkg::ST_CANCEL && cancel_hit) begin
				valid_q[cancel_idx] <= 1'b0;
			end
			if (state_q == tmq_pkg::ST_REARM && per_rdata == '0) begin
				valid_q[pick] <= 1'b0;
			end

			if (state_q == tmq_pkg::ST_EMIT_LD && out_free) begin
				emit_q <= emit_q + 1'b1;
			end

			if ((state_q == tmq_pkg::ST_EMIT_LD || state_q == tmq_pkg::ST_FINAL) &&
			    out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDXW-1:0];

		if (accept) begin
			op_q      <= s_tuser;
			exp_in_q  <= s_tdata[TIME_BITS-1:0];
			per_in_q  <= s_tdata[TIME_BITS +: PB];
			slot_in_q <= s_tdata[TIME_BITS+PB +: SB];
			gen_in_q  <= s_tdata[TIME_BITS+PB+SB +: GB];
			now_q     <= s_tdata[TIME_BITS+PB+SB+GB +: TIME_BITS];
		end

		// The final pass of a cancel or tick gives the earliest expiry.
		if (scan_done && !(op_q == tmq_pkg::OP_TICK && pick_any) &&
		    op_q != tmq_pkg::OP_ADD) begin
			nv_q <= best_any;
			ne_q <= best_any ? best : '0;
			if (op_q == tmq_pkg::OP_TICK) begin
				res_kind_q <= tmq_pkg::KIND_TICK_DONE;
				res_slot_q <= '0;
				res_gen_q  <= '0;
				res_ec_q   <= 1'b0;
			end
		end

		if (state_q == tmq_pkg::ST_CANCEL) begin
			res_kind_q <= cancel_hit ? tmq_pkg::KIND_CANCELLED : tmq_pkg::KIND_NOT_FOUND;
			res_slot_q <= slot_in_q;
			res_gen_q  <= gen_in_q;
			res_ec_q   <= 1'b0;
		end

		if (state_q == tmq_pkg::ST_ADD_WR) begin
			if (free_any) begin
				res_kind_q <= tmq_pkg::KIND_ADDED;
				res_slot_q <= SB'(free_idx);
				res_gen_q  <= gen_q[free_idx] + 1'b1;
				res_ec_q   <= add_ec;
				nv_q       <= 1'b1;
				ne_q       <= add_ec ? exp_in_q : best;
			end else begin
				res_kind_q <= tmq_pkg::KIND_FULL;
				res_slot_q <= '0;
				res_gen_q  <= '0;
				res_ec_q   <= 1'b0;
				nv_q       <= best_any;
				ne_q       <= best_any ? best : '0;
			end
		end

		if (state_q == tmq_pkg::ST_EMIT_LD && out_free) begin
			o_kind_q <= tmq_pkg::KIND_EXPIRED;
			o_slot_q <= SB'(list_rdata);
			o_gen_q  <= gen_q[list_rdata];
			o_ec_q   <= 1'b0;
			o_nv_q   <= nv_q;
			o_ne_q   <= ne_q;
			o_last_q <= 1'b0;
		end else if (state_q == tmq_pkg::ST_FINAL && out_free) begin
			o_kind_q <= res_kind_q;
			o_slot_q <= res_slot_q;
			o_gen_q  <= res_gen_q;
			o_ec_q   <= res_ec_q;
			o_nv_q   <= nv_q;
			o_ne_q   <= ne_q;
			o_last_q <= 1'b1;
		end
	end

	tmq_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (exp_waddr),
		.wdata (exp_wdata),
		.raddr (cnt_q[IDXW-1:0]),
		.rdata (exp_rdata)
	);

	tmq_ram #(.WIDTH(PB), .DEPTH(NUM_TIMERS)) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (free_idx),
		.wdata (per_in_q),
		.raddr (pick),
		.rdata (per_rdata)
	);

	tmq_ram #(.WIDTH(IDXW), .DEPTH(NUM_TIMERS)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (fill_q[IDXW-1:0]),
		.wdata (pick),
		.raddr (emit_q[IDXW-1:0]),
		.rdata (list_rdata)
	);

	tmq_scan #(.IDXW(IDXW), .TIME_BITS(TIME_BITS)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_s1),
		.value    (exp_rdata),
		.best_any (best_any),
		.best     (best),
		.pick_any (pick_any),
		.pick     (pick)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = OUT_W'({o_ne_q, o_nv_q, o_ec_q, o_gen_q, o_slot_q});

endmodule

FILE: rtl/core/tmq_checker.sv
module tmq_checker #(
	parameter int TIME_BITS = 48,
	parameter int OUT_W     = 64
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [2:0]       m_tuser,
	input logic             m_tlast
);

	// A stalled word stays on the bus.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word dropped or changed while stalled");

	// Expired words are never last; every other kind closes its operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != tmq_pkg::KIND_EXPIRED)))
		else $error("tlast does not match result kind");

	// No pending timer means a zero next expiry.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[13] |-> (m_tdata[14 +: TIME_BITS] == '0))
		else $error("next expiry nonzero without pending timer");

	// Only an added word can report a new earliest timer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> (m_tuser == tmq_pkg::KIND_ADDED) && m_tdata[13])
		else $error("earliest_changed on a word that is not an add");

endmodule

bind timer_expiry_queue_core tmq_checker #(
	.TIME_BITS (TIME_BITS),
	.OUT_W     (OUT_W)
) u_tmq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: sim/timer_expiry_queue_core_tb.sv
`timescale 1ns / 100ps

// Testbench for the timer table. A behavioral copy of the table predicts the result words of
// every accepted operation word, and each returned word is compared field by field with the
// oldest prediction. The operation stream is mostly well-formed: adds, cancels with live tags
// and ticks with a slowly advancing time, seasoned with stale tags, huge times and odd ops.
module timer_expiry_queue_core_tb;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_BITS  = 48;
	localparam int IN_W       = 144;
	localparam int OUT_W      = 64;
	localparam int WATCHDOG   = 20000;
	localparam logic [47:0] TIME_MAX = {48{1'b1}};
	// The op code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One predicted result word.
	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  gen;
		logic        ec;
		logic        nv;
		logic [47:0] nexp;
		logic        last;
	} timer_event_t;

	// Holds its own copy of the timer table and the queue of result words still to come.
	class timer_scoreboard;
		logic [47:0]  expiry [NUM_TIMERS];
		logic [31:0]  period [NUM_TIMERS];
		bit           live [NUM_TIMERS];
		logic [7:0]   tag [NUM_TIMERS];
		timer_event_t pending_events[$];
		int           errors;

		function new();
			for (int i = 0; i < NUM_TIMERS; i++) begin
				expiry[i] = '0;
				period[i] = '0;
				live[i] = 0;
				tag[i] = '0;
			end
			errors = 0;
		endfunction

		function bit soonest(output logic [47:0] t);
			bit any;
			any = 0;
			t = '0;
			for (int i = 0; i < NUM_TIMERS; i++)
				if (live[i] && (!any || expiry[i] < t)) begin
					t = expiry[i];
					any = 1;
				end
			return any;
		endfunction

		// Works out the result words of one accepted operation word.
		function void note_word(logic [1:0] op, logic [47:0] when, logic [31:0] per,
				logic [3:0] s, logic [7:0] g, logic [47:0] now);
			timer_event_t batch[$];
			timer_event_t ev;
			logic [47:0] t;
			bit any;
			bit due [NUM_TIMERS];
			int free_slot;
			int pick;
			ev = '{default: '0};
			if (op == tmq_pkg::OP_ADD) begin
				any = soonest(t);
				free_slot = -1;
				for (int i = 0; i < NUM_TIMERS; i++)
					if (!live[i] && free_slot < 0)
						free_slot = i;
				if (free_slot < 0) begin
					ev.kind = tmq_pkg::KIND_FULL;
				end else begin
					ev.kind = tmq_pkg::KIND_ADDED;
					ev.ec = !any || when < t;
					expiry[free_slot] = when;
					period[free_slot] = per;
					live[free_slot] = 1;
					tag[free_slot] = tag[free_slot] + 8'd1;
					ev.slot = 4'(free_slot);
					ev.gen = tag[free_slot];
				end
				batch.push_back(ev);
			end else if (op == tmq_pkg::OP_CANCEL) begin
				ev.slot = s;
				ev.gen = g;
				if (live[s] && tag[s] == g) begin
					live[s] = 0;
					ev.kind = tmq_pkg::KIND_CANCELLED;
				end else begin
					ev.kind = tmq_pkg::KIND_NOT_FOUND;
				end
				batch.push_back(ev);
			end else if (op == tmq_pkg::OP_TICK) begin
				for (int i = 0; i < NUM_TIMERS; i++)
					due[i] = live[i] && expiry[i] <= now;
				// Emit due timers by ascending expiry; the strict compare sends ties low.
				forever begin
					pick = -1;
					for (int i = 0; i < NUM_TIMERS; i++)
						if (due[i] && (pick < 0 || expiry[i] < expiry[pick]))
							pick = i;
					if (pick < 0)
						break;
					due[pick] = 0;
					ev = '{default: '0};
					ev.kind = tmq_pkg::KIND_EXPIRED;
					ev.slot = 4'(pick);
					ev.gen = tag[pick];
					batch.push_back(ev);
					if (period[pick] != 0) begin
						// The rearm saturates at the top of the time range.
						if ({16'd0, period[pick]} > TIME_MAX - now)
							expiry[pick] = TIME_MAX;
						else
							expiry[pick] = now + period[pick];
					end else begin
						live[pick] = 0;
					end
				end
				ev = '{default: '0};
				ev.kind = tmq_pkg::KIND_TICK_DONE;
				batch.push_back(ev);
			end
			// Every word carries the earliest expiry as it stands after the whole operation.
			any = soonest(t);
			foreach (batch[k]) begin
				batch[k].nv = any;
				batch[k].nexp = any ? t : '0;
				batch[k].last = (k == batch.size() - 1);
				pending_events.push_back(batch[k]);
			end
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check(logic [2:0] kind, logic [OUT_W-1:0] d, logic last);
			timer_event_t ev;
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual kind %0d data %0h",
					$time, kind, d);
				return;
			end
			ev = pending_events.pop_front();
			field("kind", ev.kind, kind);
			field("timer_slot", ev.slot, d[3:0]);
			field("timer_generation", ev.gen, d[11:4]);
			field("earliest_changed", ev.ec, d[12]);
			field("next_valid", ev.nv, d[13]);
			field("next_expiry", ev.nexp, d[61:14]);
			field("last", ev.last, last);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [2:0]       m_tuser;
	logic             m_tlast;

	timer_scoreboard timer_sb;
	bit              idle_enable;
	int              stall_left;
	int              quiet_cycles;
	logic [47:0]     sim_now;

	timer_expiry_queue_core #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_BITS(TIME_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: check each accepted result word, then decide on m_tready for the next edge.
	// Stalls of random length come while idling is enabled.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			timer_sb.check(m_tuser, m_tdata, m_tlast);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: too long without any word moving on either side ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("%0t: watchdog timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Presents one operation word and holds it until accepted. A random gap may come first;
	// s_tvalid stays high between back-to-back words.
	task automatic send_word(logic [1:0] op, logic [47:0] when, logic [31:0] per,
			logic [3:0] s, logic [7:0] g, logic [47:0] now);
		int gap;
		gap = 0;
		if (idle_enable && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, now, g, s, per, when};
		do @(posedge clk); while (!s_tready);
		timer_sb.note_word(op, when, per, s, g, now);
	endtask

	task automatic add_timer(logic [47:0] when, logic [31:0] per);
		send_word(tmq_pkg::OP_ADD, when, per, 4'($urandom), 8'($urandom),
			48'({$urandom, $urandom}));
	endtask

	task automatic cancel_timer(logic [3:0] s, logic [7:0] g);
		send_word(tmq_pkg::OP_CANCEL, 48'({$urandom, $urandom}), $urandom, s, g,
			48'({$urandom, $urandom}));
	endtask

	task automatic tick(logic [47:0] now);
		send_word(tmq_pkg::OP_TICK, 48'({$urandom, $urandom}), $urandom, 4'($urandom),
			8'($urandom), now);
	endtask

	initial begin
		int pick;
		logic [3:0] s;
		timer_sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = tmq_pkg::OP_ADD;
		m_tready = 1'b0;
		stall_left = 0;
		quiet_cycles = 0;
		idle_enable = 1'b1;
		sim_now = 48'd1000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first tick sees an empty table and ends with only its closing word.
		tick(48'd0);
		// Fill the table, with the extremes of time and period and a tie on the expiry.
		add_timer(48'd500, 32'd0);
		add_timer(48'd500, 32'd100);
		add_timer(48'd0, 32'd0);
		add_timer(TIME_MAX, 32'hFFFF_FFFF);
		add_timer(48'd800, 32'hFFFF_FFFF);
		for (int i = 5; i < NUM_TIMERS; i++)
			add_timer(48'd1000 + 48'(i * 10), (i % 2) ? 32'd50 : 32'd0);
		// A full table refuses the add.
		add_timer(48'd1, 32'd1);
		// Cancel with a matching tag, then with a stale tag, then on the freed slot.
		cancel_timer(4'd15, timer_sb.tag[15]);
		cancel_timer(4'd14, timer_sb.tag[14] + 8'd1);
		cancel_timer(4'd15, timer_sb.tag[15]);
		// The unused op leaves the table alone and returns nothing.
		send_word(OP_UNUSED, TIME_MAX, 32'hFFFF_FFFF, 4'hF, 8'hFF, TIME_MAX);
		// Expire the early group, ties included, then one that saturates its rearm.
		tick(48'd1100);
		tick(TIME_MAX - 48'd5);
		tick(TIME_MAX);
		for (int i = 0; i < NUM_TIMERS; i++)
			if (timer_sb.live[i])
				cancel_timer(4'(i), timer_sb.tag[i]);
		tick(TIME_MAX);

		// Random part: well-formed traffic around a slowly moving time, with some noise.
		for (int n = 0; n < 245; n++) begin
			if (n == 210)
				idle_enable = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				if ($urandom_range(0, 15) == 0)
					add_timer(48'({$urandom, $urandom}), $urandom);
				else
					add_timer(sim_now + 48'($urandom_range(0, 400)),
						($urandom_range(0, 2) == 0) ? $urandom_range(1, 300) : 32'd0);
			end else if (pick < 65) begin
				s = 4'($urandom);
				if ($urandom_range(0, 4) == 0)
					cancel_timer(s, 8'($urandom));
				else
					cancel_timer(s, timer_sb.tag[s]);
			end else if (pick < 97) begin
				sim_now = sim_now + 48'($urandom_range(0, 150));
				tick(sim_now);
			end else if (pick < 99) begin
				tick(48'({$urandom, $urandom}));
			end else begin
				send_word(OP_UNUSED, 48'({$urandom, $urandom}), $urandom, 4'($urandom),
					8'($urandom), 48'({$urandom, $urandom}));
			end
		end
		s_tvalid <= 1'b0;

		while (timer_sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (timer_sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
